// File: rtl/assert_macros.svh
// assertion macros shared by the sccb master rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every clock edge outside reset
`define SCCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sccb assertion failed");
// check on every clock edge, reset included
`define SCCB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sccb assertion failed");
`else
`define SCCB_ASSERT(lbl, prop)
`define SCCB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/sccb_pkg.sv
// shared types and constants of the sccb register master
package sccb_pkg;

  // reset values of the configuration registers
  localparam logic [6:0]  DEV_ADDR_RST   = 7'h30;
  localparam logic [15:0] SLOT_TICKS_RST = 16'd1000;

  // slot count of each transaction type
  localparam logic [6:0] WRITE_SLOTS = 7'd86;
  localparam logic [6:0] READ_SLOTS  = 7'd111;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DEV_ADDR   = 1'b0,
    CFG_SLOT_TICKS = 1'b1
  } cfg_idx_t;

  // input item kinds
  typedef enum logic [0:0] {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // line levels of one slot
  typedef struct packed {
    logic scl;
    logic sda;
    logic sample;
  } slot_t;

  // one result beat
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } res_t;

endpackage

// File: rtl/sccb_slot_dec.sv
// slot decoder: scl/sda levels and sample flag for one slot index
module sccb_slot_dec (
  input  logic [6:0]     idx,
  input  logic           read_mode,
  input  logic [6:0]     dev_addr,
  input  logic [7:0]     reg_byte,
  input  logic [7:0]     data_byte,
  output sccb_pkg::slot_t lines
);

  logic       byte_en;
  logic [7:0] byte_val;
  logic [4:0] off;
  logic [8:0] prod;
  logic [3:0] bit_num;
  logic [4:0] three_bit;
  logic [1:0] phase;
  logic [6:0] rel;

  // bit number = off / 3 via reciprocal multiply, valid for off below 27
  assign prod      = {4'b0, off} * 9'd11;
  assign bit_num   = prod[8:5];
  assign three_bit = {bit_num, 1'b0} + {1'b0, bit_num};
  assign phase     = 2'(off - three_bit);

  always_comb begin
    lines    = '{scl: 1'b1, sda: 1'b1, sample: 1'b0};
    byte_en  = 1'b0;
    byte_val = 8'h00;
    off      = 5'd0;
    rel      = 7'd0;
    if (idx < 7'd3) begin
      // start condition
      lines.scl = (idx < 7'd2);
      lines.sda = (idx == 7'd0);
    end else if (idx < 7'd30) begin
      byte_en  = 1'b1;
      byte_val = {dev_addr, 1'b0};
      off      = 5'(idx - 7'd3);
    end else if (idx < 7'd57) begin
      byte_en  = 1'b1;
      byte_val = reg_byte;
      off      = 5'(idx - 7'd30);
    end else if (!read_mode) begin
      if (idx < 7'd84) begin
        byte_en  = 1'b1;
        byte_val = data_byte;
        off      = 5'(idx - 7'd57);
      end else begin
        // stop condition
        lines.scl = 1'b1;
        lines.sda = (idx != 7'd84);
      end
    end else if (idx < 7'd59) begin
      lines.scl = 1'b1;
      lines.sda = (idx != 7'd57);
    end else if (idx < 7'd60) begin
      // idle slot between stop and restart
      lines.scl = 1'b1;
      lines.sda = 1'b1;
    end else if (idx < 7'd63) begin
      lines.scl = (idx < 7'd62);
      lines.sda = (idx == 7'd60);
    end else if (idx < 7'd90) begin
      byte_en  = 1'b1;
      byte_val = {dev_addr, 1'b1};
      off      = 5'(idx - 7'd63);
    end else if (idx < 7'd106) begin
      // receive: scl high on even slots, sampled at their end
      rel          = idx - 7'd90;
      lines.sda    = 1'b1;
      lines.scl    = ~rel[0];
      lines.sample = ~rel[0];
    end else if (idx < 7'd109) begin
      // nack bit
      byte_en  = 1'b1;
      byte_val = 8'hFF;
      off      = 5'(idx - 7'd82);
    end else begin
      lines.scl = 1'b1;
      lines.sda = (idx != 7'd109);
    end

    // shared byte slot: data, scl high, scl low; bit 8 is the ack
    if (byte_en) begin
      lines.scl = (phase == 2'd1);
      lines.sda = (bit_num < 4'd8) ? byte_val[~bit_num[2:0]] : 1'b1;
    end
  end

endmodule

// File: rtl/sccb_core.sv
// transaction state, slot prescaler and next result computation
`include "assert_macros.svh"

module sccb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_sel,
  input  logic [15:0]       cfg_wdata,
  input  logic              push,
  input  logic              kind,
  input  logic              is_read,
  input  logic [7:0]        reg_addr,
  input  logic [7:0]        write_data,
  input  logic              sda_in,
  output sccb_pkg::res_t    res
);

  logic [6:0]  dev_addr_r;
  logic [15:0] slot_ticks_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic        active_r, active_nxt;
  logic        read_mode_r, read_mode_nxt;
  logic [7:0]  reg_byte_r, reg_byte_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic        done, rejected;
  logic [15:0] slot_len;
  logic [16:0] cnt_inc;
  logic [6:0]  idx_inc;
  logic [6:0]  end_idx;
  sccb_pkg::slot_t cur_lines;
  sccb_pkg::slot_t nxt_lines;

  // lines of the slot now ending, for the receive sample
  sccb_slot_dec u_dec_cur (
    .idx       (idx_r),
    .read_mode (read_mode_r),
    .dev_addr  (dev_addr_r),
    .reg_byte  (reg_byte_r),
    .data_byte (data_byte_r),
    .lines     (cur_lines)
  );

  // lines after the beat, shown in the result
  sccb_slot_dec u_dec_nxt (
    .idx       (idx_nxt),
    .read_mode (read_mode_nxt),
    .dev_addr  (dev_addr_r),
    .reg_byte  (reg_byte_nxt),
    .data_byte (data_byte_nxt),
    .lines     (nxt_lines)
  );

  assign slot_len = (slot_ticks_r == 16'd0) ? 16'd1 : slot_ticks_r;
  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;
  assign idx_inc  = idx_r + 7'd1;
  assign end_idx  = read_mode_r ? sccb_pkg::READ_SLOTS : sccb_pkg::WRITE_SLOTS;

  // next state for one input beat
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    read_mode_nxt = read_mode_r;
    reg_byte_nxt  = reg_byte_r;
    data_byte_nxt = data_byte_r;
    rx_shift_nxt  = rx_shift_r;
    done          = 1'b0;
    rejected      = 1'b0;
    if (kind == sccb_pkg::KIND_CMD) begin
      if (active_r) begin
        rejected = 1'b1;
      end else begin
        active_nxt    = 1'b1;
        read_mode_nxt = is_read;
        reg_byte_nxt  = reg_addr;
        data_byte_nxt = write_data;
        idx_nxt       = 7'd0;
        cnt_nxt       = 16'd0;
      end
    end else if (active_r) begin
      if (cnt_inc >= {1'b0, slot_len}) begin
        if (cur_lines.sample) begin
          rx_shift_nxt = {rx_shift_r[6:0], sda_in};
        end
        cnt_nxt = 16'd0;
        idx_nxt = idx_inc;
        if (idx_inc >= end_idx) begin
          active_nxt = 1'b0;
          idx_nxt    = 7'd0;
          done       = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_inc[15:0];
      end
    end
  end

  // result beat from the new state
  always_comb begin
    res.scl          = active_nxt ? nxt_lines.scl : 1'b1;
    res.sda_out      = active_nxt ? nxt_lines.sda : 1'b1;
    res.busy_res     = active_nxt;
    res.done_res     = done;
    res.read_data    = rx_shift_nxt;
    res.cmd_rejected = rejected;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= sccb_pkg::DEV_ADDR_RST;
      slot_ticks_r <= sccb_pkg::SLOT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        sccb_pkg::CFG_DEV_ADDR:   dev_addr_r   <= cfg_wdata[6:0];
        sccb_pkg::CFG_SLOT_TICKS: slot_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      active_r    <= 1'b0;
      read_mode_r <= 1'b0;
      reg_byte_r  <= '0;
      data_byte_r <= '0;
      rx_shift_r  <= 8'hFF;
    end else if (push) begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      active_r    <= active_nxt;
      read_mode_r <= read_mode_nxt;
      reg_byte_r  <= reg_byte_nxt;
      data_byte_r <= data_byte_nxt;
      rx_shift_r  <= rx_shift_nxt;
    end
  end

  `SCCB_ASSERT(a_done_ends_txn, push && done |=> !active_r && idx_r == 7'd0)
  `SCCB_ASSERT(a_reject_only_busy, push && rejected |-> active_r)
  `SCCB_ASSERT(a_idx_in_range, active_r |-> idx_r < end_idx)

endmodule

// File: rtl/sccb_out_buf.sv
// two-entry result buffer between the core and the output channel
`include "assert_macros.svh"

module sccb_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sccb_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output sccb_pkg::res_t out_data
);

  sccb_pkg::res_t ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `SCCB_ASSERT_ALWAYS(a_cnt_bound, !rst_n || cnt_r != 2'd3)
  `SCCB_ASSERT(a_no_push_full, full |-> !push)

endmodule

// File: rtl/sccb_register_master.sv
// top level of the sccb register master
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | kind, is_read, reg_addr, write_data, sda_in
// out_    | output    | out_valid/out_stall| scl, sda_out, busy_res, done_res, read_data,
//         |           |                    | cmd_rejected
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one beat in per cycle while in_stall is low; its result leaves the buffer the next cycle at the earliest
// state update and result decode are combinational between the input and the buffer
// a two-entry result buffer lets input flow on while a result waits; in_stall rises
// only when both entries are held
// synchronous active-low reset; configuration registers load their defaults, cfg_ready
// is always high
module sccb_register_master (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_is_read,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_data,
  output logic        out_cmd_rejected,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic           accept;
  logic           full;
  sccb_pkg::res_t core_res;
  sccb_pkg::res_t buf_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // state machine and slot decode
  sccb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_sel    (cfg_index),
    .cfg_wdata  (cfg_data),
    .push       (accept),
    .kind       (in_kind),
    .is_read    (in_is_read),
    .reg_addr   (in_reg_addr),
    .write_data (in_write_data),
    .sda_in     (in_sda_in),
    .res        (core_res)
  );

  // result buffer
  sccb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (buf_res)
  );

  assign out_scl          = buf_res.scl;
  assign out_sda_out      = buf_res.sda_out;
  assign out_busy_res     = buf_res.busy_res;
  assign out_done_res     = buf_res.done_res;
  assign out_read_data    = buf_res.read_data;
  assign out_cmd_rejected = buf_res.cmd_rejected;

endmodule

// File: bench/sccb_slot_checker.sv
`timescale 1ns / 100ps
// slot sequence predictor and result beat comparator for the sccb register master
module sccb_slot_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic        in_is_read,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_scl,
  input  logic        out_sda_out,
  input  logic        out_busy_res,
  input  logic        out_done_res,
  input  logic [7:0]  out_read_data,
  input  logic        out_cmd_rejected,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        xact_busy
);

  // both lines released, nothing sampled
  localparam sccb_pkg::slot_t IDLE_LINES = '{scl: 1'b1, sda: 1'b1, sample: 1'b0};

  // shadow registers and transfer state
  logic [6:0]     dev_addr;
  logic [15:0]    slot_len;
  logic [15:0]    tick_cnt;
  logic [6:0]     slot_pos;
  logic           in_xact;
  logic           rd_mode;
  logic [7:0]     reg_byte;
  logic [7:0]     data_byte;
  logic [7:0]     rx_shift;
  sccb_pkg::res_t expected_lines[$];
  int             err_n = 0;

  // start condition: both high, sda falls, scl falls
  function automatic sccb_pkg::slot_t start_levels(int o);
    sccb_pkg::slot_t s;
    s.scl    = (o < 2);
    s.sda    = (o == 0);
    s.sample = 1'b0;
    return s;
  endfunction

  // stop condition: sda rises while scl is high
  function automatic sccb_pkg::slot_t stop_levels(int o);
    sccb_pkg::slot_t s;
    s.scl    = 1'b1;
    s.sda    = (o != 0);
    s.sample = 1'b0;
    return s;
  endfunction

  // eight data bits msb first then the released ack bit, three slots per bit
  function automatic sccb_pkg::slot_t byte_levels(logic [7:0] b, int o);
    sccb_pkg::slot_t s;
    int              bit_n;
    bit_n    = o / 3;
    s.scl    = (o % 3 == 1);
    s.sda    = (bit_n < 8) ? b[7 - bit_n] : 1'b1;
    s.sample = 1'b0;
    return s;
  endfunction

  // line levels of one slot of the running transfer
  function automatic sccb_pkg::slot_t slot_levels(int idx);
    sccb_pkg::slot_t s;
    logic [7:0]      addr_wr;
    addr_wr = {dev_addr, 1'b0};
    s = IDLE_LINES;
    if (idx < 3) s = start_levels(idx);
    else if (idx < 30) s = byte_levels(addr_wr, idx - 3);
    else if (idx < 57) s = byte_levels(reg_byte, idx - 30);
    else if (!rd_mode) begin
      if (idx < 84) s = byte_levels(data_byte, idx - 57);
      else s = stop_levels(idx - 84);
    end
    // read: stop, one released slot, restart with the read address
    else if (idx < 59) s = stop_levels(idx - 57);
    else if (idx < 60) s = IDLE_LINES;
    else if (idx < 63) s = start_levels(idx - 60);
    else if (idx < 90) s = byte_levels(addr_wr | 8'h01, idx - 63);
    else if (idx < 106) begin
      // receive: scl high with a sample at its end, then scl low
      s.sda    = 1'b1;
      s.scl    = ((idx - 90) % 2 == 0);
      s.sample = s.scl;
    end
    // nack then stop
    else if (idx < 109) s = byte_levels(8'hFF, 24 + idx - 106);
    else s = stop_levels(idx - 109);
    return s;
  endfunction

  // advance the transfer by one input beat and return the lines after it
  function automatic sccb_pkg::res_t predict_lines(logic kind, logic rd, logic [7:0] ra,
                                                   logic [7:0] wd, logic sd);
    sccb_pkg::res_t  r;
    sccb_pkg::slot_t s;
    int              len;
    r = '0;
    if (sccb_pkg::kind_t'(kind) == sccb_pkg::KIND_CMD) begin
      if (in_xact) r.cmd_rejected = 1'b1;
      else begin
        in_xact   = 1'b1;
        rd_mode   = rd;
        reg_byte  = ra;
        data_byte = wd;
        slot_pos  = '0;
        tick_cnt  = '0;
      end
    end else if (in_xact) begin
      len = (slot_len == 16'd0) ? 1 : int'(slot_len);
      if (int'(tick_cnt) + 1 >= len) begin
        s = slot_levels(int'(slot_pos));
        if (s.sample) rx_shift = {rx_shift[6:0], sd};
        tick_cnt = '0;
        slot_pos = slot_pos + 7'd1;
        if (slot_pos >= (rd_mode ? sccb_pkg::READ_SLOTS : sccb_pkg::WRITE_SLOTS)) begin
          in_xact   = 1'b0;
          slot_pos  = '0;
          r.done_res = 1'b1;
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    if (in_xact) s = slot_levels(int'(slot_pos));
    else s = IDLE_LINES;
    r.scl       = s.scl;
    r.sda_out   = s.sda;
    r.busy_res  = in_xact;
    r.read_data = rx_shift;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track
    sccb_pkg::res_t want;
    if (!rst_n) begin
      dev_addr  = sccb_pkg::DEV_ADDR_RST;
      slot_len  = sccb_pkg::SLOT_TICKS_RST;
      tick_cnt  = '0;
      slot_pos  = '0;
      in_xact   = 1'b0;
      rd_mode   = 1'b0;
      reg_byte  = '0;
      data_byte = '0;
      rx_shift  = 8'hFF;
      expected_lines.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_lines.size() == 0) begin
          $error("result beat with no prediction waiting");
          err_n++;
        end else begin
          want = expected_lines.pop_front();
          err_n += field_bad("scl", want.scl, out_scl);
          err_n += field_bad("sda_out", want.sda_out, out_sda_out);
          err_n += field_bad("busy_res", want.busy_res, out_busy_res);
          err_n += field_bad("done_res", want.done_res, out_done_res);
          err_n += field_bad("read_data", want.read_data, out_read_data);
          err_n += field_bad("cmd_rejected", want.cmd_rejected, out_cmd_rejected);
        end
      end
      // register writes
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        if (sccb_pkg::cfg_idx_t'(cfg_index) == sccb_pkg::CFG_DEV_ADDR)
          dev_addr = cfg_data[6:0];
        else if (sccb_pkg::cfg_idx_t'(cfg_index) == sccb_pkg::CFG_SLOT_TICKS)
          slot_len = cfg_data;
      end
      // input beat taken
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_lines.push_back(predict_lines(in_kind, in_is_read, in_reg_addr,
                                               in_write_data, in_sda_in));
    end
    fail_count <= err_n;
    pending    <= expected_lines.size();
    xact_busy  <= in_xact;
  end

endmodule

// File: bench/sccb_register_master_tb.sv
`timescale 1ns / 100ps
// stimulus, clocking and verdict for the sccb register master bench
module sccb_register_master_tb;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASE_BEATS   = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic        in_is_read;
  logic [7:0]  in_reg_addr;
  logic [7:0]  in_write_data;
  logic        in_sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_data;
  logic        out_cmd_rejected;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  logic        xact_busy;

  logic [15:0] cur_slot_ticks;
  logic        tx_calm;
  logic        rx_calm;
  int          rx_hold;
  int          beat_n;
  int          quiet_n;
  int          cyc_n;

  sccb_register_master uut (.*);

  sccb_slot_checker chk (.*);

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // one input beat after a random gap, held until taken
  task automatic send_beat(input sccb_pkg::kind_t k, input logic rd, input logic [7:0] ra,
                           input logic [7:0] wd, input logic sd);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_is_read    <= rd;
    in_reg_addr   <= ra;
    in_write_data <= wd;
    in_sda_in     <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the input until every predicted beat has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sccb_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == sccb_pkg::CFG_SLOT_TICKS) cur_slot_ticks = value;
  endtask

  // tick until no transfer is running
  task automatic finish_xact();
    settle();
    while (xact_busy) begin
      repeat (32) send_beat(sccb_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom));
      settle();
    end
  endtask

  // command followed by its ticks, or a random share of them, with stray commands
  task automatic run_xact(input logic rd, input logic [7:0] ra, input logic [7:0] wd,
                          input logic full);
    int len;
    int n_ticks;
    len = (cur_slot_ticks == 16'd0) ? 1 : int'(cur_slot_ticks);
    n_ticks = len * int'(rd ? sccb_pkg::READ_SLOTS : sccb_pkg::WRITE_SLOTS);
    if (!full) n_ticks = $urandom_range(0, n_ticks);
    tx_calm = ($urandom_range(0, 3) == 0);
    send_beat(sccb_pkg::KIND_CMD, rd, ra, wd, 1'($urandom));
    beat_n++;
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_beat(sccb_pkg::KIND_CMD, 1'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom));
        beat_n++;
      end
      send_beat(sccb_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
      beat_n++;
      if ($urandom_range(0, 63) == 0) settle();
    end
  endtask

  // result side: random stall after each taken beat, calm stretches now and then
  always @(posedge clk) begin : rx_side
    int n;
    cyc_n <= cyc_n + 1;
    if (cyc_n % 128 == 0) rx_calm <= ($urandom_range(0, 3) == 0);
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && !out_stall) begin
      n = rx_calm ? 0 : $urandom_range(0, 9);
      rx_hold   <= n;
      out_stall <= (n != 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold   <= 0;
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_n <= 0;
    end else if (quiet_n >= QUIET_LIMIT) begin
      $display("sccb_register_master_tb NOT OK");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = sccb_pkg::KIND_TICK;
    in_is_read     = 1'b0;
    in_reg_addr    = '0;
    in_write_data  = '0;
    in_sda_in      = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = sccb_pkg::CFG_DEV_ADDR;
    cfg_data       = '0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    rx_hold        = 0;
    beat_n         = 0;
    quiet_n        = 0;
    cyc_n          = 0;
    cur_slot_ticks = sccb_pkg::SLOT_TICKS_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: tick while idle, write start, command while busy
    send_beat(sccb_pkg::KIND_TICK, 1'b1, 8'hFF, 8'hFF, 1'b1);
    send_beat(sccb_pkg::KIND_CMD, 1'b0, 8'hFF, 8'h00, 1'b0);
    send_beat(sccb_pkg::KIND_CMD, 1'b1, 8'h00, 8'hFF, 1'b1);
    repeat (5) send_beat(sccb_pkg::KIND_TICK, 1'b0, 8'h00, 8'h00, 1'b0);
    settle();

    // slot length zero counts as one, top device address, the write runs to its end
    write_reg(sccb_pkg::CFG_SLOT_TICKS, 16'd0);
    write_reg(sccb_pkg::CFG_DEV_ADDR, 16'h007F);
    finish_xact();

    // full read at address zero, write data ignored
    write_reg(sccb_pkg::CFG_DEV_ADDR, 16'h0000);
    write_reg(sccb_pkg::CFG_SLOT_TICKS, 16'd1);
    run_xact(1'b1, 8'hFF, 8'hA5, 1'b1);
    finish_xact();

    // longest slot: the counter runs but no slot ends, then the slot is shortened
    write_reg(sccb_pkg::CFG_SLOT_TICKS, 16'hFFFF);
    write_reg(sccb_pkg::CFG_DEV_ADDR, 16'hFF55);
    send_beat(sccb_pkg::KIND_CMD, 1'b0, 8'h3C, 8'hC3, 1'b0);
    repeat (40) send_beat(sccb_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom));
    settle();
    write_reg(sccb_pkg::CFG_SLOT_TICKS, 16'd2);
    finish_xact();

    // random transfers with stray commands and partial runs
    write_reg(sccb_pkg::CFG_DEV_ADDR, 16'($urandom_range(0, 127)));
    write_reg(sccb_pkg::CFG_SLOT_TICKS, 16'd1);
    beat_n = 0;
    while (beat_n < PHASE_BEATS) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4))
          send_beat(sccb_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
      run_xact(1'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0);
    end
    finish_xact();

    // let any late beat show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sccb_register_master_tb OK");
    end else begin
      $display("sccb_register_master_tb NOT OK");
    end
    $finish;
  end

endmodule
